@@ hw/rtl/miu_pkg.sv @@
// Shared types and constants of the integer execute unit.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none
package miu_pkg;

  localparam int unsigned RegCount = 32;
  localparam int unsigned RegIdxW  = $clog2(RegCount);

  // Operation codes.
  localparam logic [6:0] OP_ADD = 7'd0, OP_ADDI = 7'd1, OP_ADDIU = 7'd2, OP_ADDU = 7'd3;
  localparam logic [6:0] OP_AND = 7'd4, OP_ANDI = 7'd5, OP_BREAK = 7'd6, OP_DADD = 7'd7;
  localparam logic [6:0] OP_DADDI = 7'd8, OP_DADDIU = 7'd9, OP_DADDU = 7'd10;
  localparam logic [6:0] OP_DIV = 7'd11, OP_DIV1 = 7'd12, OP_DIVU = 7'd13, OP_DIVU1 = 7'd14;
  localparam logic [6:0] OP_DSLL = 7'd15, OP_DSLL32 = 7'd16, OP_DSLLV = 7'd17;
  localparam logic [6:0] OP_DSRA = 7'd18, OP_DSRA32 = 7'd19, OP_DSRAV = 7'd20;
  localparam logic [6:0] OP_DSRL = 7'd21, OP_DSRL32 = 7'd22, OP_DSRLV = 7'd23;
  localparam logic [6:0] OP_DSUB = 7'd24, OP_DSUBU = 7'd25, OP_LUI = 7'd26;
  localparam logic [6:0] OP_MFHI = 7'd27, OP_MFHI1 = 7'd28, OP_MFLO = 7'd29, OP_MFLO1 = 7'd30;
  localparam logic [6:0] OP_MFSA = 7'd31, OP_MOVN = 7'd32, OP_MOVZ = 7'd33;
  localparam logic [6:0] OP_MTHI = 7'd34, OP_MTHI1 = 7'd35, OP_MTLO = 7'd36, OP_MTLO1 = 7'd37;
  localparam logic [6:0] OP_MTSA = 7'd38, OP_MTSAB = 7'd39, OP_MTSAH = 7'd40;
  localparam logic [6:0] OP_MULT = 7'd41, OP_MULT1 = 7'd42, OP_MULTU = 7'd43;
  localparam logic [6:0] OP_MULTU1 = 7'd44, OP_NOR = 7'd45, OP_OR = 7'd46, OP_ORI = 7'd47;
  localparam logic [6:0] OP_SLL = 7'd48, OP_SLLV = 7'd49, OP_SLT = 7'd50, OP_SLTI = 7'd51;
  localparam logic [6:0] OP_SLTIU = 7'd52, OP_SLTU = 7'd53, OP_SRA = 7'd54, OP_SRAV = 7'd55;
  localparam logic [6:0] OP_SRL = 7'd56, OP_SRLV = 7'd57, OP_SUB = 7'd58, OP_SUBU = 7'd59;
  localparam logic [6:0] OP_SYSCALL = 7'd60, OP_TEQ = 7'd61, OP_TEQI = 7'd62, OP_TGE = 7'd63;
  localparam logic [6:0] OP_TGEI = 7'd64, OP_TGEU = 7'd65, OP_TGEIU = 7'd66, OP_TLT = 7'd67;
  localparam logic [6:0] OP_TLTI = 7'd68, OP_TLTU = 7'd69, OP_TLTIU = 7'd70, OP_TNE = 7'd71;
  localparam logic [6:0] OP_TNEI = 7'd72, OP_XOR = 7'd73, OP_XORI = 7'd74;

  // Exception codes.
  localparam logic [2:0] EXC_NONE = 3'd0, EXC_OVF = 3'd1, EXC_TRAP = 3'd2;
  localparam logic [2:0] EXC_BREAK = 3'd3, EXC_SYSCALL = 3'd4;

  // Hi/lo pipeline selection codes.
  localparam logic [1:0] HL_NONE = 2'd0, HL_P0 = 2'd1, HL_P1 = 2'd2;

  localparam logic [5:0] DivSteps = 6'd32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the transaction fields
    logic rf_read;   // register file read data is being registered
    logic execute;   // single-cycle operation result is registered
    logic iter_init; // load the multiply/divide unit
    logic iter_step; // one multiply/divide iteration
    logic iter_fin;  // form hi/lo from the iterative unit
    logic commit;    // update the architectural state
  } miu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_iter;   // captured operation uses the iterative unit
    logic iter_last; // final iteration in progress
  } miu_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/miu_ctrl.sv @@
// Controller of the integer execute unit: sequences read, execute or iterate, and commit.
// Depends on miu_pkg.
`default_nettype none
module miu_ctrl
  import miu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output miu_cmd_t       cmd,
  input  wire miu_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_ITER, ST_FIN, ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // The next transaction may enter while the last result still waits.
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rf_read = 1'b1;
        state_nxt   = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.is_iter) begin
          cmd.iter_init = 1'b1;
          state_nxt     = ST_ITER;
        end else begin
          cmd.execute = 1'b1;
          state_nxt   = ST_COMMIT;
        end
      end
      ST_ITER: begin
        cmd.iter_step = 1'b1;
        if (stat.iter_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.iter_fin = 1'b1;
        state_nxt    = ST_COMMIT;
      end
      ST_COMMIT: begin
        // The output register must be free before the result is placed.
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/miu_datapath.sv @@
// Datapath of the integer execute unit: register file, ALU, shifter,
// iterative multiply/divide unit, hi/lo and shift-amount registers.
// Depends on miu_pkg.
`default_nettype none
module miu_datapath
  import miu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire miu_cmd_t           cmd,
  output miu_stat_t               stat,
  input  wire logic [6:0]         in_op,
  input  wire logic [4:0]         in_src_a_index,
  input  wire logic [4:0]         in_src_b_index,
  input  wire logic [4:0]         in_dest_index,
  input  wire logic signed [15:0] in_immediate,
  input  wire logic [4:0]         in_shift_amount,
  output logic [2:0]              out_exception_code,
  output logic                    out_reg_written,
  output logic [4:0]              out_written_index,
  output logic [63:0]             out_written_value,
  output logic [1:0]              out_hilo_written,
  output logic [63:0]             out_hi_result,
  output logic [63:0]             out_lo_result
);

  // Captured transaction fields.
  logic [6:0]          op_r;
  logic [RegIdxW-1:0]  rs_r, rt_r, rd_r;
  logic [15:0]         imm_r;
  logic [4:0]          sh_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      rs_r  <= in_src_a_index;
      rt_r  <= in_src_b_index;
      rd_r  <= in_dest_index;
      imm_r <= in_immediate;
      sh_r  <= in_shift_amount;
    end
  end

  // Register file with a valid bit per entry; invalid entries read as zero.
  logic [63:0]         rf_mem [RegCount];
  logic [RegCount-1:0] rf_vld_r;
  logic [63:0]         a_r, b_r;

  always_ff @(posedge clk) begin
    if (cmd.rf_read) begin
      a_r <= rf_vld_r[rs_r] ? rf_mem[rs_r] : 64'd0;
      b_r <= rf_vld_r[rt_r] ? rf_mem[rt_r] : 64'd0;
    end
  end

  // Architectural hi/lo pairs and the shift-amount register.
  logic [63:0] hi0_r, hi1_r, lo0_r, lo1_r;
  logic [31:0] sa_r;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  logic        is_mul, is_div, is_sgn, is_p1;
  always_comb begin
    is_mul = (op_r == OP_MULT) || (op_r == OP_MULT1) || (op_r == OP_MULTU) ||
             (op_r == OP_MULTU1);
    is_div = (op_r == OP_DIV) || (op_r == OP_DIV1) || (op_r == OP_DIVU) ||
             (op_r == OP_DIVU1);
    is_sgn = (op_r == OP_MULT) || (op_r == OP_MULT1) || (op_r == OP_DIV) ||
             (op_r == OP_DIV1);
    is_p1  = (op_r == OP_MULT1) || (op_r == OP_MULTU1) || (op_r == OP_DIV1) ||
             (op_r == OP_DIVU1);
  end

  // Single-cycle operations.
  logic [63:0] simm, zimm, sum_ab, dif_ab, sum_ai;
  logic [31:0] s32;
  logic [5:0]  shamt;
  logic [63:0] sh_src, shl, shr;
  logic        lt_s_ab, lt_u_ab, lt_s_ai, lt_u_ai, eq_ab, eq_ai;
  logic [2:0]  exc;
  logic        wr;
  logic [4:0]  widx;
  logic [63:0] wval;
  logic [1:0]  hsel;
  logic [63:0] nhi, nlo;
  logic [31:0] sa_nxt;
  logic        sa_wr;

  always_comb begin
    simm    = {{48{imm_r[15]}}, imm_r};
    zimm    = {48'd0, imm_r};
    sum_ab  = a_r + b_r;
    dif_ab  = a_r - b_r;
    sum_ai  = a_r + simm;
    lt_s_ab = $signed(a_r) < $signed(b_r);
    lt_u_ab = a_r < b_r;
    lt_s_ai = $signed(a_r) < $signed(simm);
    lt_u_ai = a_r < simm;
    eq_ab   = a_r == b_r;
    eq_ai   = a_r == simm;

    // Shifter: one count and one source chosen by the operation.
    case (op_r)
      OP_DSLL, OP_DSRA, OP_DSRL:       shamt = {1'b0, sh_r};
      OP_DSLL32, OP_DSRA32, OP_DSRL32: shamt = {1'b1, sh_r};
      OP_DSLLV, OP_DSRAV, OP_DSRLV:    shamt = a_r[5:0];
      OP_SLLV, OP_SRAV, OP_SRLV:       shamt = {1'b0, a_r[4:0]};
      default:                         shamt = {1'b0, sh_r};
    endcase
    case (op_r)
      OP_SRA, OP_SRAV:                 sh_src = sx32(b_r[31:0]);
      OP_SRL, OP_SRLV:                 sh_src = {32'd0, b_r[31:0]};
      default:                         sh_src = b_r;
    endcase
    shl = sh_src << shamt;
    if (op_r == OP_DSRA || op_r == OP_DSRA32 || op_r == OP_DSRAV ||
        op_r == OP_SRA || op_r == OP_SRAV) begin
      shr = $unsigned($signed(sh_src) >>> shamt);
    end else begin
      shr = sh_src >> shamt;
    end

    exc    = EXC_NONE;
    wr     = 1'b0;
    widx   = rd_r;
    wval   = 64'd0;
    hsel   = HL_NONE;
    nhi    = 64'd0;
    nlo    = 64'd0;
    sa_nxt = sa_r;
    sa_wr  = 1'b0;
    s32    = 32'd0;

    case (op_r)
      OP_ADD: begin
        s32 = sum_ab[31:0];
        if ((a_r[31] ^ s32[31]) & (b_r[31] ^ s32[31])) exc = EXC_OVF;
        else begin wr = 1'b1; wval = sx32(s32); end
      end
      OP_SUB: begin
        s32 = dif_ab[31:0];
        if ((a_r[31] ^ b_r[31]) & (a_r[31] ^ s32[31])) exc = EXC_OVF;
        else begin wr = 1'b1; wval = sx32(s32); end
      end
      OP_ADDI: begin
        s32 = sum_ai[31:0];
        if ((a_r[31] ^ s32[31]) & (simm[31] ^ s32[31])) exc = EXC_OVF;
        else begin wr = 1'b1; widx = rt_r; wval = sx32(s32); end
      end
      OP_ADDIU: begin wr = 1'b1; widx = rt_r; wval = sx32(sum_ai[31:0]); end
      OP_ADDU:  begin wr = 1'b1; wval = sx32(sum_ab[31:0]); end
      OP_AND:   begin wr = 1'b1; wval = a_r & b_r; end
      OP_ANDI:  begin wr = 1'b1; widx = rt_r; wval = a_r & zimm; end
      OP_BREAK: exc = EXC_BREAK;
      OP_DADD: begin
        if ((a_r[63] ^ sum_ab[63]) & (b_r[63] ^ sum_ab[63])) exc = EXC_OVF;
        else begin wr = 1'b1; wval = sum_ab; end
      end
      OP_DSUB: begin
        if ((a_r[63] ^ b_r[63]) & (a_r[63] ^ dif_ab[63])) exc = EXC_OVF;
        else begin wr = 1'b1; wval = dif_ab; end
      end
      OP_DADDI: begin
        if ((a_r[63] ^ sum_ai[63]) & (simm[63] ^ sum_ai[63])) exc = EXC_OVF;
        else begin wr = 1'b1; widx = rt_r; wval = sum_ai; end
      end
      OP_DADDIU: begin wr = 1'b1; widx = rt_r; wval = sum_ai; end
      OP_DADDU:  begin wr = 1'b1; wval = sum_ab; end
      OP_DSLL, OP_DSLL32, OP_DSLLV: begin wr = 1'b1; wval = shl; end
      OP_DSRA, OP_DSRA32, OP_DSRAV, OP_DSRL, OP_DSRL32, OP_DSRLV,
      OP_SRA, OP_SRAV: begin wr = 1'b1; wval = shr; end
      OP_SRL, OP_SRLV: begin wr = 1'b1; wval = sx32(shr[31:0]); end
      OP_SLL, OP_SLLV: begin wr = 1'b1; wval = sx32(shl[31:0]); end
      OP_DSUBU: begin wr = 1'b1; wval = dif_ab; end
      OP_SUBU:  begin wr = 1'b1; wval = sx32(dif_ab[31:0]); end
      OP_LUI:   begin wr = 1'b1; widx = rt_r; wval = sx32({imm_r, 16'd0}); end
      OP_MFHI:  begin wr = 1'b1; wval = hi0_r; end
      OP_MFHI1: begin wr = 1'b1; wval = hi1_r; end
      OP_MFLO:  begin wr = 1'b1; wval = lo0_r; end
      OP_MFLO1: begin wr = 1'b1; wval = lo1_r; end
      OP_MFSA:  begin wr = 1'b1; wval = {32'd0, sa_r}; end
      OP_MOVN:  begin wr = (b_r != 64'd0); wval = a_r; end
      OP_MOVZ:  begin wr = (b_r == 64'd0); wval = a_r; end
      OP_MTHI:  begin hsel = HL_P0; nhi = a_r; nlo = lo0_r; end
      OP_MTHI1: begin hsel = HL_P1; nhi = a_r; nlo = lo1_r; end
      OP_MTLO:  begin hsel = HL_P0; nhi = hi0_r; nlo = a_r; end
      OP_MTLO1: begin hsel = HL_P1; nhi = hi1_r; nlo = a_r; end
      OP_MTSA:  begin sa_wr = 1'b1; sa_nxt = a_r[31:0]; end
      OP_MTSAB: begin sa_wr = 1'b1; sa_nxt = {25'd0, a_r[3:0] ^ imm_r[3:0], 3'd0}; end
      OP_MTSAH: begin sa_wr = 1'b1; sa_nxt = {25'd0, a_r[2:0] ^ imm_r[2:0], 4'd0}; end
      OP_NOR:   begin wr = 1'b1; wval = ~(a_r | b_r); end
      OP_OR:    begin wr = 1'b1; wval = a_r | b_r; end
      OP_ORI:   begin wr = 1'b1; widx = rt_r; wval = a_r | zimm; end
      OP_SLT:   begin wr = 1'b1; wval = {63'd0, lt_s_ab}; end
      OP_SLTI:  begin wr = 1'b1; widx = rt_r; wval = {63'd0, lt_s_ai}; end
      OP_SLTIU: begin wr = 1'b1; widx = rt_r; wval = {63'd0, lt_u_ai}; end
      OP_SLTU:  begin wr = 1'b1; wval = {63'd0, lt_u_ab}; end
      OP_SYSCALL: exc = EXC_SYSCALL;
      OP_TEQ:   if (eq_ab)    exc = EXC_TRAP;
      OP_TEQI:  if (eq_ai)    exc = EXC_TRAP;
      OP_TGE:   if (!lt_s_ab) exc = EXC_TRAP;
      OP_TGEI:  if (!lt_s_ai) exc = EXC_TRAP;
      OP_TGEU:  if (!lt_u_ab) exc = EXC_TRAP;
      OP_TGEIU: if (!lt_u_ai) exc = EXC_TRAP;
      OP_TLT:   if (lt_s_ab)  exc = EXC_TRAP;
      OP_TLTI:  if (lt_s_ai)  exc = EXC_TRAP;
      OP_TLTU:  if (lt_u_ab)  exc = EXC_TRAP;
      OP_TLTIU: if (lt_u_ai)  exc = EXC_TRAP;
      OP_TNE:   if (!eq_ab)   exc = EXC_TRAP;
      OP_TNEI:  if (!eq_ai)   exc = EXC_TRAP;
      OP_XOR:   begin wr = 1'b1; wval = a_r ^ b_r; end
      OP_XORI:  begin wr = 1'b1; widx = rt_r; wval = a_r ^ zimm; end
      default: ;
    endcase
  end

  // Iterative unit: shift-add multiply and restoring divide on magnitudes,
  // one bit per cycle.
  logic [31:0] mag_a, mag_b;
  logic        neg_a, neg_b;
  logic [31:0] acc_r, q_r, dvs_r;
  logic [5:0]  cnt_r;
  logic        qneg_r, rneg_r, dz_r;
  logic [32:0] acc_sh, trial;
  logic [32:0] madd;
  logic [63:0] prod, pmag;
  logic [31:0] quo, rem;

  always_comb begin
    neg_a  = is_sgn && a_r[31];
    neg_b  = is_sgn && b_r[31];
    mag_a  = neg_a ? (32'd0 - a_r[31:0]) : a_r[31:0];
    mag_b  = neg_b ? (32'd0 - b_r[31:0]) : b_r[31:0];
    // Divide: shift remainder left by one quotient bit and try a subtract.
    acc_sh = {acc_r, q_r[31]};
    trial  = acc_sh - {1'b0, dvs_r};
    // Multiply: add multiplicand when the low multiplier bit is set.
    madd   = {1'b0, acc_r} + (q_r[0] ? {1'b0, dvs_r} : 33'd0);
    pmag   = {acc_r, q_r};
    prod   = qneg_r ? (64'd0 - pmag) : pmag;
    quo    = qneg_r ? (32'd0 - q_r) : q_r;
    rem    = rneg_r ? (32'd0 - acc_r) : acc_r;
    stat.is_iter   = is_mul || is_div;
    stat.iter_last = (cnt_r == DivSteps - 6'd1);
  end

  always_ff @(posedge clk) begin
    if (cmd.iter_init) begin
      acc_r  <= 32'd0;
      q_r    <= is_mul ? mag_b : mag_a;
      dvs_r  <= is_mul ? mag_a : mag_b;
      cnt_r  <= 6'd0;
      qneg_r <= neg_a ^ neg_b;
      rneg_r <= neg_a;
      dz_r   <= (b_r[31:0] == 32'd0);
    end else if (cmd.iter_step) begin
      cnt_r <= cnt_r + 6'd1;
      if (is_mul) begin
        {acc_r, q_r} <= {madd, q_r[31:1]};
      end else if (!trial[32]) begin
        acc_r <= trial[31:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        acc_r <= acc_sh[31:0];
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

  // Result register, loaded from either the ALU or the iterative unit.
  logic [2:0]  res_exc_r;
  logic        res_wr_r;
  logic [4:0]  res_widx_r;
  logic [63:0] res_wval_r;
  logic [1:0]  res_hsel_r;
  logic [63:0] res_hi_r, res_lo_r;
  logic        res_sa_wr_r;
  logic [31:0] res_sa_r;
  logic        wr_eff;

  assign wr_eff = wr && (widx != 5'd0);

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_exc_r   <= exc;
      res_wr_r    <= wr_eff;
      res_widx_r  <= wr_eff ? widx : 5'd0;
      res_wval_r  <= wr_eff ? wval : 64'd0;
      res_hsel_r  <= hsel;
      res_hi_r    <= nhi;
      res_lo_r    <= nlo;
      res_sa_wr_r <= sa_wr;
      res_sa_r    <= sa_nxt;
    end else if (cmd.iter_fin) begin
      res_exc_r   <= EXC_NONE;
      res_wr_r    <= 1'b0;
      res_widx_r  <= 5'd0;
      res_wval_r  <= 64'd0;
      res_hsel_r  <= is_p1 ? HL_P1 : HL_P0;
      res_sa_wr_r <= 1'b0;
      res_sa_r    <= sa_r;
      if (is_mul) begin
        res_hi_r <= sx32(prod[63:32]);
        res_lo_r <= sx32(prod[31:0]);
      end else if (dz_r) begin
        // Divide by zero: hi keeps the dividend, lo is all ones or one.
        res_hi_r <= sx32(a_r[31:0]);
        res_lo_r <= (is_sgn && a_r[31]) ? 64'd1 : {64{1'b1}};
      end else begin
        // Signed minimum over minus one falls out of the magnitude divide.
        res_hi_r <= sx32(rem);
        res_lo_r <= sx32(quo);
      end
    end
  end

  // Architectural state update.
  always_ff @(posedge clk) begin
    if (cmd.commit && res_wr_r) rf_mem[res_widx_r] <= res_wval_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      hi0_r    <= 64'd0;
      hi1_r    <= 64'd0;
      lo0_r    <= 64'd0;
      lo1_r    <= 64'd0;
      sa_r     <= 32'd0;
    end else if (cmd.commit) begin
      if (res_wr_r) rf_vld_r[res_widx_r] <= 1'b1;
      if (res_hsel_r == HL_P0) begin
        hi0_r <= res_hi_r;
        lo0_r <= res_lo_r;
      end
      if (res_hsel_r == HL_P1) begin
        hi1_r <= res_hi_r;
        lo1_r <= res_lo_r;
      end
      if (res_sa_wr_r) sa_r <= res_sa_r;
    end
  end

  // Output register, held while the result is stalled.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_exception_code <= res_exc_r;
      out_reg_written    <= res_wr_r;
      out_written_index  <= res_widx_r;
      out_written_value  <= res_wval_r;
      out_hilo_written   <= res_hsel_r;
      out_hi_result      <= (res_hsel_r == HL_NONE) ? 64'd0 : res_hi_r;
      out_lo_result      <= (res_hsel_r == HL_NONE) ? 64'd0 : res_lo_r;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mips64_integer_execute_unit.sv @@
// Integer execute unit: one transaction at a time against a 32-entry register file.
// Sequence: read, execute, commit for single-cycle operations, and read, load,
// 32 one-bit steps, finish, commit for multiply and divide; commit waits while
// the output register holds a stalled result.
// A new transaction is accepted only after the previous one has committed.
// Reset (synchronous, rst_n low) clears the register file, hi/lo pairs, shift amount.
`default_nettype none
module mips64_integer_execute_unit
  import miu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [6:0]         in_op,
  input  wire logic [4:0]         in_src_a_index,
  input  wire logic [4:0]         in_src_b_index,
  input  wire logic [4:0]         in_dest_index,
  input  wire logic signed [15:0] in_immediate,
  input  wire logic [4:0]         in_shift_amount,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_exception_code,
  output logic                    out_reg_written,
  output logic [4:0]              out_written_index,
  output logic [63:0]             out_written_value,
  output logic [1:0]              out_hilo_written,
  output logic [63:0]             out_hi_result,
  output logic [63:0]             out_lo_result
);

  miu_cmd_t  cmd;
  miu_stat_t stat;

  // Sequencer.
  miu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Execution datapath and architectural state.
  miu_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (in_op),
    .in_src_a_index     (in_src_a_index),
    .in_src_b_index     (in_src_b_index),
    .in_dest_index      (in_dest_index),
    .in_immediate       (in_immediate),
    .in_shift_amount    (in_shift_amount),
    .out_exception_code (out_exception_code),
    .out_reg_written    (out_reg_written),
    .out_written_index  (out_written_index),
    .out_written_value  (out_written_value),
    .out_hilo_written   (out_hilo_written),
    .out_hi_result      (out_hi_result),
    .out_lo_result      (out_lo_result)
  );

endmodule
`default_nettype wire

@@ test/tb_mips64_integer_execute_unit.sv @@
// Self-checking testbench for the integer execute unit: directed and random instructions.
// Depends on miu_pkg and the mips64_integer_execute_unit top level.
`timescale 1ns / 1ps
module tb_mips64_integer_execute_unit;
  import miu_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomCount = 1300;

  typedef struct {
    logic [6:0]         op;
    logic [4:0]         rs;
    logic [4:0]         rt;
    logic [4:0]         rd;
    logic signed [15:0] imm;
    logic [4:0]         sa;
    bit                 drain;
  } instr_t;

  typedef struct {
    logic [2:0]  exc;
    logic        wr;
    logic [4:0]  widx;
    logic [63:0] wval;
    logic [1:0]  hsel;
    logic [63:0] hi;
    logic [63:0] lo;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [6:0] in_op = '0;
  logic [4:0] in_src_a_index = '0;
  logic [4:0] in_src_b_index = '0;
  logic [4:0] in_dest_index = '0;
  logic signed [15:0] in_immediate = '0;
  logic [4:0] in_shift_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_exception_code;
  logic out_reg_written;
  logic [4:0] out_written_index;
  logic [63:0] out_written_value;
  logic [1:0] out_hilo_written;
  logic [63:0] out_hi_result;
  logic [63:0] out_lo_result;

  instr_t pending_instrs[$];
  outcome_t expected_outcomes[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Architectural state mirrored by the predictor.
  logic [63:0] gpr[32];
  logic [63:0] hi_copy[2];
  logic [63:0] lo_copy[2];
  logic [31:0] sa_copy;

  mips64_integer_execute_unit i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_src_a_index, .in_src_b_index,
    .in_dest_index, .in_immediate, .in_shift_amount, .out_valid, .out_stall,
    .out_exception_code, .out_reg_written, .out_written_index, .out_written_value,
    .out_hilo_written, .out_hi_result, .out_lo_result
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] sext32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Signed or unsigned 32-bit divide, including the divide-by-zero and overflow results.
  function automatic void divide32(logic [63:0] a, logic [63:0] b, bit sgn,
                                   output logic [63:0] hi, output logic [63:0] lo);
    longint n;
    longint d;
    if (sgn) begin
      n = longint'($signed(a[31:0]));
      d = longint'($signed(b[31:0]));
    end else begin
      n = longint'({32'd0, a[31:0]});
      d = longint'({32'd0, b[31:0]});
    end
    if (d == 0) begin
      lo = (!sgn || n >= 0) ? '1 : 64'd1;
      hi = sext32(a);
    end else if (sgn && n == -64'sd2147483648 && d == -1) begin
      lo = sext32(a);
      hi = '0;
    end else begin
      lo = sext32(64'(n / d));
      hi = sext32(64'(n % d));
    end
  endfunction

  function automatic void multiply32(logic [63:0] a, logic [63:0] b, bit sgn,
                                     output logic [63:0] hi, output logic [63:0] lo);
    logic [63:0] p;
    if (sgn) p = 64'(longint'($signed(a[31:0])) * longint'($signed(b[31:0])));
    else p = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    lo = sext32(p);
    hi = sext32({32'd0, p[63:32]});
  endfunction

  // Executes one instruction on the mirrored state and returns its outcome.
  function automatic outcome_t execute_instr(instr_t t);
    outcome_t r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] zimm;
    logic [63:0] simm;
    logic [63:0] s;
    logic [63:0] nhi;
    logic [63:0] nlo;
    bit wr;
    bit trap;
    logic [4:0] widx;
    logic [63:0] wval;
    logic [1:0] hsel;
    logic [2:0] exc;
    a = gpr[t.rs];
    b = gpr[t.rt];
    zimm = {48'd0, t.imm};
    simm = {{48{t.imm[15]}}, t.imm};
    wr = 0; trap = 0; widx = t.rd; wval = '0; hsel = HL_NONE; exc = EXC_NONE;
    nhi = '0; nlo = '0;
    case (t.op)
      OP_ADD, OP_SUB: begin
        s = (t.op == OP_ADD) ? a + b : a - b;
        if (((t.op == OP_ADD) ? ((a ^ s) & (b ^ s)) : ((a ^ b) & (a ^ s))) & 64'h8000_0000)
          exc = EXC_OVF;
        else begin wr = 1; wval = sext32(s); end
      end
      OP_ADDI: begin
        s = a + simm;
        if ((a ^ s) & (simm ^ s) & 64'h8000_0000) exc = EXC_OVF;
        else begin wr = 1; widx = t.rt; wval = sext32(s); end
      end
      OP_ADDIU: begin wr = 1; widx = t.rt; wval = sext32(a + simm); end
      OP_ADDU: begin wr = 1; wval = sext32(a + b); end
      OP_AND: begin wr = 1; wval = a & b; end
      OP_ANDI: begin wr = 1; widx = t.rt; wval = a & zimm; end
      OP_BREAK: exc = EXC_BREAK;
      OP_DADD, OP_DSUB: begin
        s = (t.op == OP_DADD) ? a + b : a - b;
        if ((((t.op == OP_DADD) ? ((a ^ s) & (b ^ s)) : ((a ^ b) & (a ^ s))) >> 63) != 0)
          exc = EXC_OVF;
        else begin wr = 1; wval = s; end
      end
      OP_DADDI: begin
        s = a + simm;
        if (((a ^ s) & (simm ^ s)) >> 63) exc = EXC_OVF;
        else begin wr = 1; widx = t.rt; wval = s; end
      end
      OP_DADDIU: begin wr = 1; widx = t.rt; wval = a + simm; end
      OP_DADDU: begin wr = 1; wval = a + b; end
      OP_DIV: begin hsel = HL_P0; divide32(a, b, 1, nhi, nlo); end
      OP_DIV1: begin hsel = HL_P1; divide32(a, b, 1, nhi, nlo); end
      OP_DIVU: begin hsel = HL_P0; divide32(a, b, 0, nhi, nlo); end
      OP_DIVU1: begin hsel = HL_P1; divide32(a, b, 0, nhi, nlo); end
      OP_DSLL: begin wr = 1; wval = b << t.sa; end
      OP_DSLL32: begin wr = 1; wval = b << (t.sa + 6'd32); end
      OP_DSLLV: begin wr = 1; wval = b << a[5:0]; end
      OP_DSRA: begin wr = 1; wval = $signed(b) >>> t.sa; end
      OP_DSRA32: begin wr = 1; wval = $signed(b) >>> (t.sa + 6'd32); end
      OP_DSRAV: begin wr = 1; wval = $signed(b) >>> a[5:0]; end
      OP_DSRL: begin wr = 1; wval = b >> t.sa; end
      OP_DSRL32: begin wr = 1; wval = b >> (t.sa + 6'd32); end
      OP_DSRLV: begin wr = 1; wval = b >> a[5:0]; end
      OP_DSUBU: begin wr = 1; wval = a - b; end
      OP_LUI: begin wr = 1; widx = t.rt; wval = sext32({32'd0, t.imm, 16'd0}); end
      OP_MFHI: begin wr = 1; wval = hi_copy[0]; end
      OP_MFHI1: begin wr = 1; wval = hi_copy[1]; end
      OP_MFLO: begin wr = 1; wval = lo_copy[0]; end
      OP_MFLO1: begin wr = 1; wval = lo_copy[1]; end
      OP_MFSA: begin wr = 1; wval = {32'd0, sa_copy}; end
      OP_MOVN: if (b != 0) begin wr = 1; wval = a; end
      OP_MOVZ: if (b == 0) begin wr = 1; wval = a; end
      OP_MTHI: begin hsel = HL_P0; nhi = a; nlo = lo_copy[0]; end
      OP_MTHI1: begin hsel = HL_P1; nhi = a; nlo = lo_copy[1]; end
      OP_MTLO: begin hsel = HL_P0; nhi = hi_copy[0]; nlo = a; end
      OP_MTLO1: begin hsel = HL_P1; nhi = hi_copy[1]; nlo = a; end
      OP_MTSA: sa_copy = a[31:0];
      OP_MTSAB: sa_copy = 32'(((a[3:0] ^ zimm[3:0])) * 8);
      OP_MTSAH: sa_copy = 32'(((a[2:0] ^ zimm[2:0])) * 16);
      OP_MULT: begin hsel = HL_P0; multiply32(a, b, 1, nhi, nlo); end
      OP_MULT1: begin hsel = HL_P1; multiply32(a, b, 1, nhi, nlo); end
      OP_MULTU: begin hsel = HL_P0; multiply32(a, b, 0, nhi, nlo); end
      OP_MULTU1: begin hsel = HL_P1; multiply32(a, b, 0, nhi, nlo); end
      OP_NOR: begin wr = 1; wval = ~(a | b); end
      OP_OR: begin wr = 1; wval = a | b; end
      OP_ORI: begin wr = 1; widx = t.rt; wval = a | zimm; end
      OP_SLL: begin wr = 1; wval = sext32(b << t.sa); end
      OP_SLLV: begin wr = 1; wval = sext32(b << a[4:0]); end
      OP_SLT: begin wr = 1; wval = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0; end
      OP_SLTI: begin wr = 1; widx = t.rt; wval = ($signed(a) < $signed(simm)) ? 64'd1 : 64'd0; end
      OP_SLTIU: begin wr = 1; widx = t.rt; wval = (a < simm) ? 64'd1 : 64'd0; end
      OP_SLTU: begin wr = 1; wval = (a < b) ? 64'd1 : 64'd0; end
      OP_SRA: begin wr = 1; wval = $signed(sext32(b)) >>> t.sa; end
      OP_SRAV: begin wr = 1; wval = $signed(sext32(b)) >>> a[4:0]; end
      OP_SRL: begin wr = 1; wval = sext32({32'd0, b[31:0]} >> t.sa); end
      OP_SRLV: begin wr = 1; wval = sext32({32'd0, b[31:0]} >> a[4:0]); end
      OP_SUBU: begin wr = 1; wval = sext32(a - b); end
      OP_SYSCALL: exc = EXC_SYSCALL;
      OP_TEQ: trap = (a == b);
      OP_TEQI: trap = (a == simm);
      OP_TGE: trap = !($signed(a) < $signed(b));
      OP_TGEI: trap = !($signed(a) < $signed(simm));
      OP_TGEU: trap = (a >= b);
      OP_TGEIU: trap = (a >= simm);
      OP_TLT: trap = ($signed(a) < $signed(b));
      OP_TLTI: trap = ($signed(a) < $signed(simm));
      OP_TLTU: trap = (a < b);
      OP_TLTIU: trap = (a < simm);
      OP_TNE: trap = (a != b);
      OP_TNEI: trap = (a != simm);
      OP_XOR: begin wr = 1; wval = a ^ b; end
      OP_XORI: begin wr = 1; widx = t.rt; wval = a ^ zimm; end
      default: ;
    endcase
    if (trap) exc = EXC_TRAP;
    // Writes to register zero are dropped and reported as no write.
    if (wr && widx != 0) gpr[widx] = wval;
    else begin wr = 0; widx = '0; wval = '0; end
    if (hsel != HL_NONE) begin
      hi_copy[hsel - 1] = nhi;
      lo_copy[hsel - 1] = nlo;
    end
    r.exc = exc; r.wr = wr; r.widx = widx; r.wval = wval;
    r.hsel = hsel; r.hi = nhi; r.lo = nlo;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
    error_count++;
  endtask

  task automatic queue_instr(logic [6:0] op, logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                             logic signed [15:0] imm, logic [4:0] sa, bit drain);
    instr_t t;
    t.op = op; t.rs = rs; t.rt = rt; t.rd = rd; t.imm = imm; t.sa = sa; t.drain = drain;
    pending_instrs.push_back(t);
  endtask

  // Random instruction: mostly defined operations, some unused codes, edge immediates.
  function automatic instr_t random_instr();
    instr_t t;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) t.op = 7'($urandom_range(127, 75));
    else t.op = 7'($urandom_range(74, 0));
    t.rs = 5'($urandom);
    t.rt = 5'($urandom);
    t.rd = 5'($urandom);
    t.sa = 5'($urandom);
    pick = $urandom_range(99);
    case (pick % 10)
      0: t.imm = 16'sh8000;
      1: t.imm = 16'sh7fff;
      2: t.imm = -16'sd1;
      3: t.imm = '0;
      default: t.imm = 16'($urandom);
    endcase
    t.drain = 0;
    return t;
  endfunction

  // Stimulus: directed corner cases, then random instructions.
  initial begin
    instr_t t;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    hi_copy = '{default: '0};
    lo_copy = '{default: '0};
    sa_copy = '0;
    queue_instr(OP_LUI, 0, 1, 0, 16'sh8000, 0, 0);      // r1 = 0xffffffff80000000
    queue_instr(OP_ADDIU, 0, 2, 0, -16'sd1, 0, 0);      // r2 = all ones
    queue_instr(OP_LUI, 0, 3, 0, 16'sh7fff, 0, 0);
    queue_instr(OP_ORI, 3, 3, 0, -16'sd1, 0, 0);        // r3 = 0x7fffffff
    queue_instr(OP_DSLL32, 0, 1, 4, 0, 31, 0);          // r4 = 0, since bit 0 of r1 is clear
    queue_instr(OP_DSRL, 0, 2, 5, 0, 1, 0);             // r5 = 64-bit maximum
    queue_instr(OP_ADD, 3, 3, 6, 0, 0, 0);              // 32-bit overflow
    queue_instr(OP_ADDI, 3, 7, 0, 16'sd1, 0, 0);
    queue_instr(OP_SUB, 1, 3, 6, 0, 0, 0);
    queue_instr(OP_DADD, 5, 5, 6, 0, 0, 0);             // 64-bit overflow
    queue_instr(OP_DSUB, 4, 2, 6, 0, 0, 1);
    queue_instr(OP_DADDI, 5, 7, 0, 16'sd1, 0, 0);
    queue_instr(OP_DIV, 3, 0, 0, 0, 0, 0);              // divide by zero, positive
    queue_instr(OP_DIV1, 1, 0, 0, 0, 0, 0);             // divide by zero, negative
    queue_instr(OP_DIVU, 1, 0, 0, 0, 0, 0);
    queue_instr(OP_DIV, 1, 2, 0, 0, 0, 0);              // minimum over minus one
    queue_instr(OP_MULT1, 1, 2, 0, 0, 0, 0);
    queue_instr(OP_MULTU, 2, 2, 0, 0, 0, 0);
    queue_instr(OP_MTHI, 3, 0, 0, 0, 0, 0);             // single half move
    queue_instr(OP_MTLO1, 1, 0, 0, 0, 0, 0);
    queue_instr(OP_MTSAB, 2, 0, 0, 16'sh0003, 0, 0);
    queue_instr(OP_MFSA, 0, 0, 8, 0, 0, 0);
    queue_instr(OP_MOVN, 3, 0, 9, 0, 0, 0);             // not taken
    queue_instr(OP_MOVZ, 3, 2, 9, 0, 0, 0);             // not taken
    queue_instr(OP_ADDU, 3, 3, 0, 0, 0, 0);             // write to register zero
    queue_instr(7'd127, 31, 31, 31, -16'sd1, 31, 0);    // unused code
    for (int i = 0; i < RandomCount; i++) begin
      t = random_instr();
      t.drain = (i == RandomCount / 2);
      pending_instrs.push_back(t);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Wait for everything to be sent and answered, then let the pipeline settle.
    while (pending_instrs.size() != 0 || in_valid || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_outcomes.size() == 0)
      $display("[mips64_integer_execute_unit] OK");
    else
      $display("[mips64_integer_execute_unit] ERROR");
    $finish;
  end

  // Idling is switched off in a quiet window of the run.
  function automatic bit idle_now();
    if (cycle_count > 6000 && cycle_count < 12000) return 0;
    return $urandom_range(99) < 24;
  endfunction

  // Driver: predicts each accepted transaction and presents the next one.
  always @(posedge clk) begin
    bit taken;
    bit load;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      taken = in_valid && !in_stall;
      if (taken) begin
        instr_t cur;
        cur.op = in_op; cur.rs = in_src_a_index; cur.rt = in_src_b_index;
        cur.rd = in_dest_index; cur.imm = in_immediate; cur.sa = in_shift_amount;
        cur.drain = 0;
        expected_outcomes.push_back(execute_instr(cur));
      end
      if (!in_valid || taken) begin
        load = pending_instrs.size() != 0 && !idle_now();
        if (load && pending_instrs[0].drain && expected_outcomes.size() != 0) load = 0;
        if (load) begin
          in_op <= pending_instrs[0].op;
          in_src_a_index <= pending_instrs[0].rs;
          in_src_b_index <= pending_instrs[0].rt;
          in_dest_index <= pending_instrs[0].rd;
          in_immediate <= pending_instrs[0].imm;
          in_shift_amount <= pending_instrs[0].sa;
          void'(pending_instrs.pop_front());
        end
        in_valid <= load;
      end
    end
  end

  // Monitor: random stall and comparison of each result transaction.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          $display("unexpected result transaction at cycle %0d", cycle_count);
          error_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (out_exception_code !== want.exc)
            report_mismatch("exception_code", 64'(out_exception_code), 64'(want.exc));
          if (out_reg_written !== want.wr)
            report_mismatch("reg_written", 64'(out_reg_written), 64'(want.wr));
          if (out_written_index !== want.widx)
            report_mismatch("written_index", 64'(out_written_index), 64'(want.widx));
          if (out_written_value !== want.wval)
            report_mismatch("written_value", out_written_value, want.wval);
          if (out_hilo_written !== want.hsel)
            report_mismatch("hilo_written", 64'(out_hilo_written), 64'(want.hsel));
          if (out_hi_result !== want.hi) report_mismatch("hi_result", out_hi_result, want.hi);
          if (out_lo_result !== want.lo) report_mismatch("lo_result", out_lo_result, want.lo);
        end
      end
      out_stall <= idle_now();
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("[mips64_integer_execute_unit] ERROR");
      $finish;
    end
  end

endmodule

@@ mips64_integer_execute_unit.f @@
hw/rtl/miu_pkg.sv
hw/rtl/miu_ctrl.sv
hw/rtl/miu_datapath.sv
hw/rtl/mips64_integer_execute_unit.sv
test/tb_mips64_integer_execute_unit.sv
